// ===== hdl/sase_pkg.sv =====
// ----------------------------------------------------------------------------
// sase_pkg: shared types and constants of the sorted array set engine
// Operation codes, request classes and the queue item carried from the
// front end to the store.
// ----------------------------------------------------------------------------
package sase_pkg;

  // fixed field widths of the request and result channels
  localparam int OP_W      = 2;
  localparam int ELEMENT_W = 32;
  localparam int COUNT_W   = 7;

  // operation codes on the request channel
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // request queue between front end and store
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  // request class after decoding
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  // one decoded request
  typedef struct packed {
    kind_t                kind;
    logic [ELEMENT_W-1:0] value;
  } req_item_t;

  // head of the request queue as seen by the store
  typedef struct packed {
    logic      valid;
    req_item_t item;
  } queue_head_t;

endpackage

// ===== hdl/sase_req_if.sv =====
// ----------------------------------------------------------------------------
// sase_req_if: request channel
// Valid/ready channel carrying one operation and one value per item.
// ----------------------------------------------------------------------------
interface sase_req_if
  import sase_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [ELEMENT_W-1:0] element_value;

  modport source (output valid, output operation, output element_value, input ready);
  modport sink   (input valid, input operation, input element_value, output ready);
endinterface

// ===== hdl/sase_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sase_rsp_if: result channel
// Valid/ready channel carrying the found flag, status and entry count.
// ----------------------------------------------------------------------------
interface sase_rsp_if
  import sase_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic               status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output found, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input found, input status, input entry_count,
                  output ready);
endinterface

// ===== hdl/sase_front.sv =====
// ----------------------------------------------------------------------------
// sase_front: request front end
// Accepts request items, decodes the operation into a request class and
// holds them in a short queue until the store takes them.
// ----------------------------------------------------------------------------
module sase_front
  import sase_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sase_req_if.sink    request,
  output queue_head_t head,
  input  logic        pop
);

  req_item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_LVL_W-1:0]  level;
  req_item_t               decoded;
  logic                    push;
  logic                    do_pop;

  // decode the operation; the spare code behaves as a query
  always_comb begin
    decoded.value = request.element_value;
    unique case (request.operation)
      OP_INSERT: decoded.kind = KIND_INSERT;
      OP_REMOVE: decoded.kind = KIND_REMOVE;
      OP_QUERY:  decoded.kind = KIND_QUERY;
      default:   decoded.kind = KIND_QUERY;
    endcase
  end

  assign request.ready = (level != QUEUE_LVL_W'(QUEUE_DEPTH));
  assign push          = request.valid && request.ready;
  assign do_pop        = pop && (level != '0);

  assign head.valid = (level != '0);
  assign head.item  = slots[rd_ptr];

  // store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  // advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

// ===== hdl/sase_back.sv =====
// ----------------------------------------------------------------------------
// sase_back: sorted store and execution
// Holds the entries in a row of cells, compares every cell against the
// request value, then shifts in place to insert or remove and issues the
// result through an output register.
// ----------------------------------------------------------------------------
module sase_back
  import sase_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  sase_rsp_if.source  result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_COMPARE = 3'b010,
    ST_APPLY   = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  kind_t                  cur_kind;
  logic [VALUE_WIDTH-1:0] cur_value;
  logic [VALUE_WIDTH-1:0] head_value;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [VALUE_WIDTH-1:0] cells [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_below [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_above [CAPACITY];
  logic [CAPACITY-1:0]    lt_flags;
  logic [CAPACITY-1:0]    le_flags;
  logic [CAPACITY-1:0]    eq_flags;
  logic [CAPACITY-1:0]    le_below;
  logic                   found;
  logic                   full;
  logic                   status;
  logic                   apply_fire;
  logic                   out_free;

  // fit the request value to the store width
  if (VALUE_WIDTH > ELEMENT_W) begin : g_widen
    assign head_value = {{(VALUE_WIDTH - ELEMENT_W){1'b0}}, head.item.value};
  end else begin : g_narrow
    assign head_value = head.item.value[VALUE_WIDTH-1:0];
  end

  assign out_free   = !result.valid || result.ready;
  assign apply_fire = (state == ST_APPLY) && out_free;
  assign pop        = head.valid && ((state == ST_IDLE) || apply_fire);

  assign found  = |eq_flags;
  assign full   = (count == CNT_W'(CAPACITY));
  assign status = (cur_kind == KIND_INSERT) && full;

  // sequencer: take an item, compare, apply
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (head.valid) state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_APPLY;
      ST_APPLY:   if (out_free) state_next = head.valid ? ST_COMPARE : ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the item taken from the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_kind  <= head.item.kind;
      cur_value <= head_value;
    end
  end

  // next count
  always_comb begin
    count_next = count;
    case (cur_kind)
      KIND_INSERT: if (!full) count_next = count + 1'b1;
      KIND_REMOVE: if (found) count_next = count - 1'b1;
      default:     count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_fire) begin
      count <= count_next;
    end
  end

  // per-cell compare, shift and update
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   live;
    logic [VALUE_WIDTH-1:0] cell_next;

    if (i == 0) begin : g_first
      assign cell_below[i] = cur_value;
      assign le_below[i]   = 1'b1;
    end else begin : g_rest
      assign cell_below[i] = cells[i-1];
      assign le_below[i]   = le_flags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign cell_above[i] = cells[i];
    end else begin : g_inner
      assign cell_above[i] = cells[i+1];
    end

    assign live = (CNT_W'(i) < count);

    // register the compare flags of this cell
    always_ff @(posedge clk) begin
      if (state == ST_COMPARE) begin
        lt_flags[i] <= live && (cells[i] <  cur_value);
        le_flags[i] <= live && (cells[i] <= cur_value);
        eq_flags[i] <= live && (cells[i] == cur_value);
      end
    end

    // insert after equal entries, remove the first equal entry
    always_comb begin
      cell_next = cells[i];
      case (cur_kind)
        KIND_INSERT: begin
          if (!full && !le_flags[i]) begin
            cell_next = le_below[i] ? cur_value : cell_below[i];
          end
        end
        KIND_REMOVE: begin
          if (found && !lt_flags[i]) begin
            cell_next = cell_above[i];
          end
        end
        default: cell_next = cells[i];
      endcase
    end

    always_ff @(posedge clk) begin
      if (apply_fire) begin
        cells[i] <= cell_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (apply_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      result.found  <= found;
      result.status <= status;
    end
  end

  if (CNT_W >= COUNT_W) begin : g_cnt_trim
    always_ff @(posedge clk) begin
      if (apply_fire) begin
        result.entry_count <= count_next[COUNT_W-1:0];
      end
    end
  end else begin : g_cnt_pad
    always_ff @(posedge clk) begin
      if (apply_fire) begin
        result.entry_count <= {{(COUNT_W - CNT_W){1'b0}}, count_next};
      end
    end
  end

endmodule

// ===== hdl/sorted_array_set_engine_top.sv =====
// Path: a request passes the queue, the item latch, the compare flags and the result
//   register. Sequencing: the store sequencer takes each item through its compare and
//   apply steps, finishes one item before reading the next and holds in apply until the result is taken.
// Reset: synchronous, active high; clears the count, queue and result valid;
//   stored entries are left as they are and only entries below the count are read.
// ----------------------------------------------------------------------------
// sorted_array_set_engine_top: sorted multiset engine
// Front end decodes and queues requests; the back end keeps the ascending
// store, inserts, removes and looks up values and returns one result each.
// ----------------------------------------------------------------------------
module sorted_array_set_engine_top
  import sase_pkg::*;
#(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  sase_req_if.sink   request,
  sase_rsp_if.source result
);

  queue_head_t head;
  logic        pop;

  // decode and queue requests
  sase_front u_front (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .head    (head),
    .pop     (pop)
  );

  // execute against the sorted store
  sase_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== sim/tb_sorted_array_set_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_array_set_engine_top: self-checking bench of the sorted multiset
// A queue of requests drives the request channel through a clocked driver
// that idles at random. Each accepted item is applied to a local ascending
// store, and the found flag, status and count that it gives are queued. A
// clocked monitor stalls the result channel at random and checks every result
// against the oldest queued one. Random traffic runs in fill, drain and mixed
// phases so that the store reaches both empty and full.
// ----------------------------------------------------------------------------
module tb_sorted_array_set_engine_top;
  import sase_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HISTORY_MAX  = 96;
  // operation code 3 is unused and acts as a lookup
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [ELEMENT_W-1:0] value;
  } request_t;

  typedef struct {
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

  logic clk;
  logic rst;

  sase_req_if request_ch ();
  sase_rsp_if result_ch ();

  sorted_array_set_engine_top #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .request(request_ch),
    .result (result_ch)
  );

  request_t             pending_requests[$];
  outcome_t             expected_outcomes[$];
  logic [ELEMENT_W-1:0] inserted_history[$];
  logic [ELEMENT_W-1:0] value_pool[8];

  // local copy of the ascending store
  logic [ELEMENT_W-1:0] shadow_store[CAPACITY];
  int unsigned          shadow_count;

  int          error_count;
  int unsigned cycle_no;

  // ---------------------------------------------------------------------------
  // apply one request to the local store and return its outcome
  function automatic outcome_t apply_request(input logic [OP_W-1:0] op,
                                             input logic [ELEMENT_W-1:0] v);
    outcome_t    res;
    int unsigned lower;
    int unsigned upper;
    res.found  = 1'b0;
    res.status = 1'b0;
    lower = 0;
    while (lower < shadow_count && shadow_store[lower] < v)
      lower++;
    res.found = (lower < shadow_count) && (shadow_store[lower] == v);
    if (op == OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = 1'b1;
      end else begin
        // place after every equal entry
        upper = lower;
        while (upper < shadow_count && shadow_store[upper] == v)
          upper++;
        for (int i = shadow_count; i > upper; i--)
          shadow_store[i] = shadow_store[i-1];
        shadow_store[upper] = v;
        shadow_count++;
      end
    end else if (op == OP_REMOVE && res.found) begin
      // close the gap over the first equal entry
      for (int i = lower; i + 1 < shadow_count; i++)
        shadow_store[i] = shadow_store[i+1];
      shadow_count--;
    end
    res.count = shadow_count[COUNT_W-1:0];
    return res;
  endfunction

  // hold off with a chance of 31 in a hundred, except in the calm window
  function automatic bit take_break();
    if (cycle_no >= 2000 && cycle_no < 3500)
      return 1'b0;
    return $urandom_range(99) < 31;
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [ELEMENT_W-1:0] v);
    request_t req;
    req.op    = op;
    req.value = v;
    pending_requests = {pending_requests, req};
    if (op == OP_INSERT) begin
      inserted_history = {inserted_history, v};
      if (inserted_history.size() > HISTORY_MAX)
        void'(inserted_history.pop_front());
    end
  endtask

  // value for a lookup or removal: mostly one that was inserted earlier
  function automatic logic [ELEMENT_W-1:0] pick_known_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60 && inserted_history.size() != 0)
      return inserted_history[$urandom_range(inserted_history.size() - 1)];
    if (roll < 85)
      return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and cycle count
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // ---------------------------------------------------------------------------
  // drive the request channel from the pending queue
  always @(posedge clk) begin : drive_requests
    request_t next_req;
    if (rst) begin
      request_ch.valid <= 1'b0;
    end else begin
      // record the accepted item
      if (request_ch.valid && request_ch.ready)
        expected_outcomes = {expected_outcomes,
                             apply_request(request_ch.operation,
                                           request_ch.element_value)};
      // advance only when the channel is free
      if (!request_ch.valid || request_ch.ready) begin
        if (pending_requests.size() != 0 && !take_break()) begin
          next_req = pending_requests.pop_front();
          request_ch.valid         <= 1'b1;
          request_ch.operation     <= next_req.op;
          request_ch.element_value <= next_req.value;
        end else begin
          request_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stall and check the result channel
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected: found=%0d status=%0d count=%0d",
                   $time, result_ch.found, result_ch.status, result_ch.entry_count);
        end else begin
          want = expected_outcomes.pop_front();
          if (result_ch.found !== want.found) begin
            error_count++;
            $display("%0t: found mismatch: expected %0d actual %0d",
                     $time, want.found, result_ch.found);
          end
          if (result_ch.status !== want.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, result_ch.status);
          end
          if (result_ch.entry_count !== want.count) begin
            error_count++;
            $display("%0t: entry_count mismatch: expected %0d actual %0d",
                     $time, want.count, result_ch.entry_count);
          end
        end
      end
      result_ch.ready <= !take_break();
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  initial begin : stimulus
    phase_t phase;
    int     random_left;
    int     span;
    int     roll;
    logic [OP_W-1:0] op;
    logic [ELEMENT_W-1:0] v;

    error_count   = 0;
    cycle_no      = 0;
    shadow_count  = 0;
    rst           = 1'b1;
    request_ch.valid         = 1'b0;
    request_ch.operation     = OP_QUERY;
    request_ch.element_value = '0;
    result_ch.ready          = 1'b0;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++)
      value_pool[i] = $urandom;

    // directed: empty store, extremes, duplicates, absent removal, spare code
    queue_request(OP_QUERY,  32'h0000_0000);
    queue_request(OP_REMOVE, 32'h0000_0005);
    queue_request(OP_INSERT, 32'hFFFF_FFFF);
    queue_request(OP_INSERT, 32'h0000_0000);
    queue_request(OP_INSERT, 32'h8000_0000);
    queue_request(OP_INSERT, 32'h8000_0000);
    queue_request(OP_INSERT, 32'h7FFF_FFFF);
    queue_request(OP_QUERY,  32'h8000_0000);
    queue_request(OP_SPARE,  32'h8000_0000);
    queue_request(OP_SPARE,  32'h1234_5678);
    queue_request(OP_REMOVE, 32'h8000_0001);
    queue_request(OP_REMOVE, 32'h8000_0000);
    queue_request(OP_REMOVE, 32'h8000_0000);
    queue_request(OP_REMOVE, 32'h8000_0000);
    queue_request(OP_QUERY,  32'hFFFF_FFFF);
    queue_request(OP_INSERT, 32'h5555_5555);
    queue_request(OP_INSERT, 32'hAAAA_AAAA);
    queue_request(OP_REMOVE, 32'h0000_0000);
    queue_request(OP_REMOVE, 32'hFFFF_FFFF);
    queue_request(OP_REMOVE, 32'h7FFF_FFFF);
    queue_request(OP_REMOVE, 32'h5555_5555);
    queue_request(OP_REMOVE, 32'hAAAA_AAAA);
    queue_request(OP_REMOVE, 32'hAAAA_AAAA);
    queue_request(OP_QUERY,  32'hAAAA_AAAA);

    // random phases; the first one fills the store past capacity
    random_left = RANDOM_ITEMS;
    phase = PHASE_FILL;
    while (random_left > 0) begin
      span = $urandom_range(160, 40);
      if (phase == PHASE_FILL && random_left == RANDOM_ITEMS)
        span = 100;
      for (int i = 0; i < span && random_left > 0; i++) begin
        roll = $urandom_range(99);
        case (phase)
          PHASE_FILL: begin
            op = (roll < 85) ? OP_INSERT : (roll < 92) ? OP_QUERY : OP_REMOVE;
          end
          PHASE_DRAIN: begin
            op = (roll < 80) ? OP_REMOVE : (roll < 88) ? OP_QUERY : OP_INSERT;
          end
          default: begin
            op = (roll < 40) ? OP_INSERT : (roll < 75) ? OP_REMOVE : OP_QUERY;
          end
        endcase
        if ($urandom_range(99) < 3)
          op = OP_SPARE;
        if (op == OP_INSERT)
          v = ($urandom_range(1)) ? value_pool[$urandom_range(7)] : $urandom;
        else
          v = pick_known_value();
        queue_request(op, v);
        random_left--;
      end
      phase = phase_t'($urandom_range(2));
    end

    // release reset
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // drain the stimulus and the outstanding results
    while (pending_requests.size() != 0 || request_ch.valid)
      @(posedge clk);
    while (expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS sorted_array_set_engine_top");
    end else begin
      $display("FAIL sorted_array_set_engine_top");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // guard against a hung channel
  initial begin
    #3000000;
    $display("FAIL sorted_array_set_engine_top");
    $finish;
  end

endmodule
